>>> rtl/aabb_matrix_transform_top_defines.svh
// assertion helpers used by the top-level rtl
`ifndef AABB_MATRIX_TRANSFORM_TOP_DEFINES_SVH
`define AABB_MATRIX_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication
`define AABBT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aabbt assertion failed");

// next-cycle implication
`define AABBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aabbt assertion failed");

`endif

>>> rtl/aabbt_pkg.sv
package aabbt_pkg;

   localparam int COORD_W    = 32;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = 3 * COEF_W;
   localparam int PROD_W     = COEF_W + COORD_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 12;
   localparam int QUOT_W     = SUM_W - FRAC_SHIFT;
   localparam int AXES       = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Z = 3'd5;

   localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [QUOT_W-1:0]  quot_type;
   typedef logic [ROW_W-1:0]          row_type;

   typedef prod_type [AXES-1:0][AXES-1:0] prod_mat_type;

   typedef struct packed {
      row_type   [AXES-1:0] row;
      coord_type [AXES-1:0] shift;
   } cfg_type;

   typedef struct packed {
      coord_type [AXES-1:0] lo;
      coord_type [AXES-1:0] hi;
   } box_type;

   // products [out axis][in axis] for the lower and upper corner coordinate
   typedef struct packed {
      prod_mat_type p_lo;
      prod_mat_type p_hi;
   } prod_set_type;

   typedef struct packed {
      prod_mat_type t_min;
      prod_mat_type t_max;
   } term_set_type;

   typedef struct packed {
      sum_type [AXES-1:0] s_min;
      sum_type [AXES-1:0] s_max;
   } sum_set_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

>>> rtl/aabbt_if.sv
interface aabbt_req_if;
   import aabbt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type min_x;
   coord_type min_y;
   coord_type min_z;
   coord_type max_x;
   coord_type max_y;
   coord_type max_z;

   modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
   modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface aabbt_rsp_if;
   import aabbt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type out_min_x;
   coord_type out_min_y;
   coord_type out_min_z;
   coord_type out_max_x;
   coord_type out_max_y;
   coord_type out_max_z;

   modport source (output valid, out_min_x, out_min_y, out_min_z,
                   out_max_x, out_max_y, out_max_z, input ready);
   modport sink (input valid, out_min_x, out_min_y, out_min_z,
                 out_max_x, out_max_y, out_max_z, output ready);
endinterface

>>> rtl/aabbt_csr.sv
module aabbt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [aabbt_pkg::CSR_IDX_W-1:0]      index,
   input  logic [aabbt_pkg::CSR_DATA_W-1:0]     wdata,
   output aabbt_pkg::cfg_type                   cfg
);
   import aabbt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_ROW_X:   cfg_in.row[0]   = wdata;
            CSR_ROW_Y:   cfg_in.row[1]   = wdata;
            CSR_ROW_Z:   cfg_in.row[2]   = wdata;
            CSR_SHIFT_X: cfg_in.shift[0] = coord_type'(wdata[COORD_W-1:0]);
            CSR_SHIFT_Y: cfg_in.shift[1] = coord_type'(wdata[COORD_W-1:0]);
            CSR_SHIFT_Z: cfg_in.shift[2] = coord_type'(wdata[COORD_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row[0] <= ROW_X_RESET;
         cfg_ff.row[1] <= ROW_Y_RESET;
         cfg_ff.row[2] <= ROW_Z_RESET;
         cfg_ff.shift  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> rtl/aabbt_mul.sv
module aabbt_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  aabbt_pkg::cfg_type        cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  aabbt_pkg::box_type        box,
   output aabbt_pkg::hs_type         out_hs,
   input  logic                      out_ready,
   output aabbt_pkg::prod_set_type   prod
);
   import aabbt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         advance;
   prod_set_type prod_ff;
   prod_set_type prod_in;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // coefficient times both candidate coordinates, per output and input axis
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         for (int j = 0; j < AXES; j++) begin
            prod_in.p_lo[a][j] = prod_type'(coef_type'(cfg.row[a][j*COEF_W +: COEF_W]))
                                 * prod_type'(box.lo[j]);
            prod_in.p_hi[a][j] = prod_type'(coef_type'(cfg.row[a][j*COEF_W +: COEF_W]))
                                 * prod_type'(box.hi[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_hs.valid = valid_ff;
   assign out_hs.ready = advance;
   assign prod         = prod_ff;
endmodule

>>> rtl/aabbt_sel.sv
module aabbt_sel (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  aabbt_pkg::prod_set_type   prod,
   output aabbt_pkg::hs_type         out_hs,
   input  logic                      out_ready,
   output aabbt_pkg::term_set_type   term
);
   import aabbt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         advance;
   term_set_type term_ff;
   term_set_type term_in;

   assign advance  = !valid_ff || out_ready;
   assign valid_in = advance ? in_valid : valid_ff;

   // each term depends on one input axis only, so the corner extremes
   // separate into per-term min and max
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         for (int j = 0; j < AXES; j++) begin
            if ($signed(prod.p_lo[a][j]) < $signed(prod.p_hi[a][j])) begin
               term_in.t_min[a][j] = prod.p_lo[a][j];
               term_in.t_max[a][j] = prod.p_hi[a][j];
            end else begin
               term_in.t_min[a][j] = prod.p_hi[a][j];
               term_in.t_max[a][j] = prod.p_lo[a][j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         term_ff <= term_in;
      end
   end

   assign out_hs.valid = valid_ff;
   assign out_hs.ready = advance;
   assign term         = term_ff;
endmodule

>>> rtl/aabbt_acc.sv
module aabbt_acc (
   input  logic                      clock,
   input  logic                      reset,
   input  aabbt_pkg::cfg_type        cfg,
   input  logic                      in_valid,
   input  aabbt_pkg::term_set_type   term,
   output aabbt_pkg::hs_type         out_hs,
   input  logic                      out_ready,
   output aabbt_pkg::sum_set_type    sum
);
   import aabbt_pkg::*;

   localparam sum_type ROUND_HALF = sum_type'(1) <<< (FRAC_SHIFT - 1);

   logic        valid_ff;
   logic        valid_in;
   logic        advance;
   sum_set_type sum_ff;
   sum_set_type sum_in;
   sum_type     base;

   assign advance  = !valid_ff || out_ready;
   assign valid_in = advance ? in_valid : valid_ff;

   always_comb begin
      base = '0;
      for (int a = 0; a < AXES; a++) begin
         // translation lifted to the product scale, plus the rounding half
         base = (sum_type'(cfg.shift[a]) <<< FRAC_SHIFT) + ROUND_HALF;
         sum_in.s_min[a] = base + sum_type'(term.t_min[a][0])
                         + sum_type'(term.t_min[a][1]) + sum_type'(term.t_min[a][2]);
         sum_in.s_max[a] = base + sum_type'(term.t_max[a][0])
                         + sum_type'(term.t_max[a][1]) + sum_type'(term.t_max[a][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_hs.valid = valid_ff;
   assign out_hs.ready = advance;
   assign sum          = sum_ff;
endmodule

>>> rtl/aabbt_fin.sv
module aabbt_fin (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  aabbt_pkg::sum_set_type                    sum,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output aabbt_pkg::coord_type [aabbt_pkg::AXES-1:0] res_min,
   output aabbt_pkg::coord_type [aabbt_pkg::AXES-1:0] res_max
);
   import aabbt_pkg::*;

   localparam quot_type Q_MAX = quot_type'({1'b0, {(COORD_W-1){1'b1}}});
   localparam quot_type Q_MIN = -Q_MAX - quot_type'(1);

   logic                  valid_ff;
   logic                  valid_in;
   logic                  advance;
   coord_type [AXES-1:0]  min_ff;
   coord_type [AXES-1:0]  max_ff;
   coord_type [AXES-1:0]  min_in;
   coord_type [AXES-1:0]  max_in;

   function automatic coord_type round_sat(input sum_type s);
      quot_type q;
      coord_type r;
      // arithmetic shift is the floor of the division
      q = quot_type'(s >>> FRAC_SHIFT);
      if (q > Q_MAX) begin
         r = coord_type'(Q_MAX);
      end else if (q < Q_MIN) begin
         r = coord_type'(Q_MIN);
      end else begin
         r = coord_type'(q);
      end
      return r;
   endfunction

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         min_in[a] = round_sat(sum.s_min[a]);
         max_in[a] = round_sat(sum.s_max[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign out_valid = valid_ff;
   assign res_min   = min_ff;
   assign res_max   = max_ff;
endmodule

>>> rtl/aabb_matrix_transform_top.sv
// Maps an axis-aligned box (Q16.16 min and max corners) through the affine
// transform held in the csr registers and returns the box spanning the eight
// mapped corners, rounded half up and saturated to 32 bits. One request is
// taken every cycle while the response side does not stall; each accepted
// request passes through four register stages (multiply, corner select, sum,
// round and saturate) before its result is presented. Registers must be
// written only while no request is in flight; the block itself does not
// enforce this. A write to an index above five is ignored.
module aabb_matrix_transform_top (
   input  logic                               clock,
   input  logic                               reset,
   aabbt_req_if.sink                          req_bus,
   aabbt_rsp_if.source                        rsp_bus,
   input  logic                               csr_wr_en,
   input  logic [aabbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aabbt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import aabbt_pkg::*;

   `include "aabb_matrix_transform_top_defines.svh"

   cfg_type              cfg;
   box_type              box;
   prod_set_type         prod;
   term_set_type         term;
   sum_set_type          sum;
   hs_type               mul_hs;
   hs_type               sel_hs;
   hs_type               acc_hs;
   logic                 fin_ready;
   coord_type [AXES-1:0] res_min;
   coord_type [AXES-1:0] res_max;

   assign box.lo[0] = req_bus.min_x;
   assign box.lo[1] = req_bus.min_y;
   assign box.lo[2] = req_bus.min_z;
   assign box.hi[0] = req_bus.max_x;
   assign box.hi[1] = req_bus.max_y;
   assign box.hi[2] = req_bus.max_z;

   aabbt_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   aabbt_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .box       (box),
      .out_hs    (mul_hs),
      .out_ready (sel_hs.ready),
      .prod      (prod)
   );

   aabbt_sel u_sel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_hs.valid),
      .prod      (prod),
      .out_hs    (sel_hs),
      .out_ready (acc_hs.ready),
      .term      (term)
   );

   aabbt_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (sel_hs.valid),
      .term      (term),
      .out_hs    (acc_hs),
      .out_ready (fin_ready),
      .sum       (sum)
   );

   aabbt_fin u_fin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_hs.valid),
      .in_ready  (fin_ready),
      .sum       (sum),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .res_min   (res_min),
      .res_max   (res_max)
   );

   assign rsp_bus.out_min_x = res_min[0];
   assign rsp_bus.out_min_y = res_min[1];
   assign rsp_bus.out_min_z = res_min[2];
   assign rsp_bus.out_max_x = res_max[0];
   assign rsp_bus.out_max_y = res_max[1];
   assign rsp_bus.out_max_z = res_max[2];

   `AABBT_ASSERT_IMPL(a_order_x, clock, reset, rsp_bus.valid,
                      $signed(rsp_bus.out_min_x) <= $signed(rsp_bus.out_max_x))
   `AABBT_ASSERT_IMPL(a_order_y, clock, reset, rsp_bus.valid,
                      $signed(rsp_bus.out_min_y) <= $signed(rsp_bus.out_max_y))
   `AABBT_ASSERT_IMPL(a_order_z, clock, reset, rsp_bus.valid,
                      $signed(rsp_bus.out_min_z) <= $signed(rsp_bus.out_max_z))
   `AABBT_ASSERT_IMPL(a_full_stall, clock, reset,
                      rsp_bus.valid && !rsp_bus.ready && mul_hs.valid && sel_hs.valid
                      && acc_hs.valid, !req_bus.ready)
   `AABBT_ASSERT_NEXT(a_accept_loads, clock, reset, req_bus.valid && req_bus.ready,
                      mul_hs.valid)
endmodule

>>> verif/aabbt_box_checker.sv
module aabbt_box_checker (
   input  logic                             clock,
   input  logic                             reset,
   aabbt_req_if                             req_mon,
   aabbt_rsp_if                             rsp_mon,
   input  logic                             csr_wr_en,
   input  logic [aabbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aabbt_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               error_count,
   output int                               boxes_outstanding
);
   import aabbt_pkg::*;

   typedef struct {
      coord_type lo [AXES];
      coord_type hi [AXES];
   } span_type;

   row_type   coef_row [AXES];
   coord_type offset [AXES];
   span_type  expected_spans [$];
   span_type  head;
   coord_type box_lo [AXES];
   coord_type box_hi [AXES];
   coord_type seen [2*AXES];
   coord_type want [2*AXES];
   string     field_label [2*AXES];
   int        errors = 0;

   initial begin
      field_label = '{"out_min_x", "out_min_y", "out_min_z",
                      "out_max_x", "out_max_y", "out_max_z"};
   end

   // one mapped coordinate: exact sum, round half up to q16.16, saturate
   function automatic coord_type map_coord(row_type row, coord_type shift,
                                           coord_type p [AXES]);
      longint acc;
      acc = 2048 + longint'(shift) * 4096;
      for (int a = 0; a < AXES; a++)
         acc += longint'(coef_type'(row[COEF_W*a +: COEF_W])) * longint'(p[a]);
      acc = acc >>> FRAC_SHIFT;
      if (acc > longint'(32'sh7fff_ffff))
         return 32'sh7fff_ffff;
      if (acc < longint'(32'sh8000_0000))
         return 32'sh8000_0000;
      return coord_type'(acc);
   endfunction

   function automatic span_type predict_span(coord_type lo [AXES], coord_type hi [AXES]);
      span_type  s;
      coord_type corner [AXES];
      coord_type m;
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < AXES; a++)
            corner[a] = (((k >> (AXES - 1 - a)) & 1) != 0) ? hi[a] : lo[a];
         for (int a = 0; a < AXES; a++) begin
            m = map_coord(coef_row[a], offset[a], corner);
            if (k == 0 || m < s.lo[a]) s.lo[a] = m;
            if (k == 0 || m > s.hi[a]) s.hi[a] = m;
         end
      end
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         coef_row[0] = ROW_X_RESET;
         coef_row[1] = ROW_Y_RESET;
         coef_row[2] = ROW_Z_RESET;
         for (int a = 0; a < AXES; a++)
            offset[a] = '0;
         expected_spans.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ROW_X:   coef_row[0] = csr_wdata[ROW_W-1:0];
               CSR_ROW_Y:   coef_row[1] = csr_wdata[ROW_W-1:0];
               CSR_ROW_Z:   coef_row[2] = csr_wdata[ROW_W-1:0];
               CSR_SHIFT_X: offset[0] = csr_wdata[COORD_W-1:0];
               CSR_SHIFT_Y: offset[1] = csr_wdata[COORD_W-1:0];
               CSR_SHIFT_Z: offset[2] = csr_wdata[COORD_W-1:0];
               default: ;
            endcase
         end
         // results leave before new requests are queued in the same cycle
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_spans.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result: out_min_x %h out_max_x %h",
                           rsp_mon.out_min_x, rsp_mon.out_max_x);
               errors++;
            end else begin
               head = expected_spans.pop_front();
               seen = '{rsp_mon.out_min_x, rsp_mon.out_min_y, rsp_mon.out_min_z,
                        rsp_mon.out_max_x, rsp_mon.out_max_y, rsp_mon.out_max_z};
               for (int a = 0; a < AXES; a++) begin
                  want[a] = head.lo[a];
                  want[a + AXES] = head.hi[a];
               end
               for (int f = 0; f < 2*AXES; f++) begin
                  if (seen[f] !== want[f]) begin
                     if (errors < 10)
                        $display("mismatch %s: expected %h (%0d) actual %h (%0d)",
                                 field_label[f], want[f], want[f], seen[f], seen[f]);
                     errors++;
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            box_lo = '{req_mon.min_x, req_mon.min_y, req_mon.min_z};
            box_hi = '{req_mon.max_x, req_mon.max_y, req_mon.max_z};
            expected_spans.push_back(predict_span(box_lo, box_hi));
         end
      end
      error_count <= errors;
      boxes_outstanding <= expected_spans.size();
   end

endmodule

>>> verif/tb_aabb_matrix_transform_top.sv
module tb_aabb_matrix_transform_top;
   import aabbt_pkg::*;

   localparam int        LONG_HOLD_CYCLES = 300;
   localparam int        DRAIN_SLACK      = 8;
   localparam int        PHASE_BOXES      = 322;
   localparam int        PHASES           = 6;
   localparam coord_type COORD_MAX        = 32'sh7fff_ffff;
   localparam coord_type COORD_MIN        = 32'sh8000_0000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    req_idle_pct = 29;
   int                    rsp_idle_pct = 76;
   bit                    long_hold_req = 1'b0;
   int                    error_count;
   int                    boxes_outstanding;

   aabbt_req_if req_bus ();
   aabbt_rsp_if rsp_bus ();

   aabb_matrix_transform_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   aabbt_box_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .error_count       (error_count),
      .boxes_outstanding (boxes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("FAIL aabb_matrix_transform_top");
      $finish;
   end

   // result side
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            // long enough for the pipeline to back up into the request side
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_bus.ready <= !(rsp_idle_pct != 0 && $urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   task automatic send_box(coord_type lx, coord_type ly, coord_type lz,
                           coord_type hx, coord_type hy, coord_type hz);
      while (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.min_x <= lx;
      req_bus.min_y <= ly;
      req_bus.min_z <= lz;
      req_bus.max_x <= hx;
      req_bus.max_y <= hy;
      req_bus.max_z <= hz;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return coord_type'($urandom_range(32) - 16);
         3, 4, 5: return coord_type'($urandom);
         default: return coord_type'($urandom_range(1 << 24) - (1 << 23));
      endcase
   endfunction

   task automatic send_random_box();
      coord_type lo [AXES];
      coord_type hi [AXES];
      for (int a = 0; a < AXES; a++) begin
         lo[a] = pick_coord();
         // mostly ordered boxes, the rest arbitrary and often inverted
         if ($urandom_range(3) != 0)
            hi[a] = lo[a] + coord_type'($urandom_range(1 << 21));
         else
            hi[a] = pick_coord();
      end
      send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   function automatic row_type rand_row(bit moderate);
      row_type r;
      for (int a = 0; a < AXES; a++)
         r[COEF_W*a +: COEF_W] = moderate ? 16'($urandom_range(8192) - 4096)
                                          : 16'($urandom);
      return r;
   endfunction

   task automatic program_transform(row_type rx, row_type ry, row_type rz,
                                    coord_type sx, coord_type sy, coord_type sz);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROW_X;
      csr_wdata <= rx;
      @(posedge clock);
      csr_index <= CSR_ROW_Y;
      csr_wdata <= ry;
      @(posedge clock);
      csr_index <= CSR_ROW_Z;
      csr_wdata <= rz;
      @(posedge clock);
      csr_index <= CSR_SHIFT_X;
      csr_wdata <= {16'($urandom), sx};
      @(posedge clock);
      csr_index <= CSR_SHIFT_Y;
      csr_wdata <= {16'($urandom), sy};
      @(posedge clock);
      csr_index <= CSR_SHIFT_Z;
      csr_wdata <= {16'($urandom), sz};
      @(posedge clock);
      // indexes above five must leave the transform alone
      csr_index <= ($urandom_range(1) != 0) ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata <= {16'($urandom), 32'($urandom)};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (boxes_outstanding != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_ROW_X;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.min_x <= '0;
      req_bus.min_y <= '0;
      req_bus.min_z <= '0;
      req_bus.max_x <= '0;
      req_bus.max_y <= '0;
      req_bus.max_z <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // identity transform out of reset
      send_box(0, 0, 0, 0, 0, 0);
      send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
      send_box(-1, 1, -65536, 65536, -1, 1);
      send_box(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
      send_box(32'sh1234_5678, -32'sh0000_abcd, 7, 32'sh1234_5678, -32'sh0000_abcd, 7);
      req_bus.valid <= 1'b0;
      wait_drained();

      // halves exercise the round-half-up tie, the shifts move the result
      program_transform(48'h0000_0000_0800, 48'h0000_f800_0000, 48'h0800_0800_0800,
                        1, -1, 0);
      send_box(1, 1, 1, 3, 3, 3);
      send_box(-1, -1, -1, -3, -3, -3);
      send_box(-1, -1, -1, 1, 1, 1);
      send_box(-3, 5, -7, 9, -11, 13);
      send_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
      send_box(COORD_MAX, -2, COORD_MAX, COORD_MAX, 2, COORD_MAX);
      send_box(0, 0, 0, 0, 0, 0);
      send_box(32'sh0000_8001, 32'sh0000_7fff, -32'sh0000_8001,
               -32'sh0000_8001, -32'sh0000_7fff, 32'sh0000_8001);
      req_bus.valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 2)
            0: begin
               req_idle_pct = 29;
               rsp_idle_pct = 76;
            end
            1: begin
               req_idle_pct = 76;
               rsp_idle_pct = 29;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         case (phase)
            0: program_transform({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
                                 COORD_MAX, COORD_MAX, COORD_MAX);
            1: program_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                                 COORD_MIN, COORD_MIN, COORD_MIN);
            3: program_transform(rand_row(1'b1), rand_row(1'b1), rand_row(1'b1),
                                 coord_type'($urandom_range(1 << 24) - (1 << 23)),
                                 coord_type'($urandom_range(1 << 24) - (1 << 23)),
                                 coord_type'($urandom_range(1 << 24) - (1 << 23)));
            4: program_transform('0, '0, '0, coord_type'($urandom),
                                 coord_type'($urandom), coord_type'($urandom));
            default: program_transform(rand_row(1'b0), rand_row(1'b0), rand_row(1'b0),
                                       coord_type'($urandom), coord_type'($urandom),
                                       coord_type'($urandom));
         endcase
         if (phase == PHASES - 1)
            long_hold_req = 1'b1;
         repeat (PHASE_BOXES) send_random_box();
         req_bus.valid <= 1'b0;
         wait_drained();
      end

      if (error_count == 0 && boxes_outstanding == 0)
         $display("PASS aabb_matrix_transform_top");
      else
         $display("FAIL aabb_matrix_transform_top");
      $finish;
   end

endmodule
